/* hdl/usm_pkg.sv */
// usm_pkg: shared types and constants for the UV sphere mesh generator.
// No dependencies.
package usm_pkg;

    typedef enum logic [2:0] {
        PH_DONE  = 3'd0,
        PH_NORTH = 3'd1,
        PH_RING  = 3'd2,
        PH_SOUTH = 3'd3,
        PH_TOP   = 3'd4,
        PH_MID   = 3'd5,
        PH_BOT   = 3'd6
    } phase_t;

    typedef enum logic [1:0] {
        REG_RADIUS  = 2'd0,
        REG_RINGS   = 2'd1,
        REG_SEGS    = 2'd2
    } reg_idx_t;

    localparam int CORDIC_STEPS = 16;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sh026DD3B6A;

    // Work item handed from the sequencer to the datapath.
    typedef struct packed {
        phase_t      phase;
        logic        ring_start;  // new ring: recompute polar sine/cosine
        logic [31:0] polar_num;   // (r+1) << 23, extended by 8 zero bits in the divider
        logic [8:0]  polar_den;   // nr+1
        logic [39:0] azi_num;     // k << 32
        logic [8:0]  azi_den;     // ns
        logic [15:0] index_a;
        logic [15:0] index_b;
        logic [15:0] index_c;
        logic        last;
    } cmd_t;

    typedef struct packed {
        logic               item_kind;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] pos_z;
        logic signed [15:0] norm_x;
        logic signed [15:0] norm_y;
        logic signed [15:0] norm_z;
        logic [15:0]        index_a;
        logic [15:0]        index_b;
        logic [15:0]        index_c;
        logic               last;
    } result_t;

    function automatic logic signed [33:0] turn_atan(input logic [3:0] i);
        logic signed [33:0] v;
        begin
            unique case (i)
                4'd0:  v = 34'sh020000000;
                4'd1:  v = 34'sh012E4051E;
                4'd2:  v = 34'sh009FB385B;
                4'd3:  v = 34'sh0051111D4;
                4'd4:  v = 34'sh0028B0D43;
                4'd5:  v = 34'sh00145D7E1;
                4'd6:  v = 34'sh000A2F61E;
                4'd7:  v = 34'sh000517C55;
                4'd8:  v = 34'sh00028BE53;
                4'd9:  v = 34'sh000145F2F;
                4'd10: v = 34'sh0000A2F98;
                4'd11: v = 34'sh0000517CC;
                4'd12: v = 34'sh000028BE6;
                4'd13: v = 34'sh0000145F3;
                4'd14: v = 34'sh00000A2FA;
                default: v = 34'sh00000517D;
            endcase
            return v;
        end
    endfunction

endpackage

/* hdl/usm_if.sv */
// usm_if: valid/ready channel carrying one word of payload type T.
// Depends on nothing; payload types come from usm_pkg.
interface usm_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* hdl/uv_sphere_mesh_generator.sv */
// The first vertex of each ring keeps the datapath busy through two 40-step
// shift-subtract angle divisions, two 16-step CORDIC passes and five shared multiplies,
// other ring vertices through one division, one CORDIC pass and the multiplies,
// poles through the radius multiplies only; triangles skip all of these. A result
// waiting on the output holds the datapath. The divider is serial and there is a
// single CORDIC unit. A two-word command queue lets the sequencer accept further
// restart/advance words while the datapath works. Words arriving after the final
// triangle, before a restart, produce no result.
// Top level; depends on usm_pkg, usm_if, usm_front, usm_queue, usm_back.
module uv_sphere_mesh_generator #(
    parameter int MAX_DIVISIONS = 255,
    parameter int FRAC_BITS     = 14
) (
    input  logic        clk,
    input  logic        rst_n,
    usm_if.sink         in_ch,
    usm_if.source       out_ch,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [14:0] cfg_data
);
    import usm_pkg::*;

    logic [14:0] radius_reg;
    logic [7:0]  rings_reg;
    logic [7:0]  segs_reg;

    logic  f_valid, f_ready, b_valid, b_ready;
    cmd_t  f_cmd, b_cmd;
    result_t r;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= 15'd256;
            rings_reg  <= 8'd8;
            segs_reg   <= 8'd16;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_RADIUS: radius_reg <= cfg_data;
                REG_RINGS:  rings_reg  <= cfg_data[7:0];
                REG_SEGS:   segs_reg   <= cfg_data[7:0];
                default:
                begin
                end
            endcase
        end
    end

    usm_front #(.MAX_DIVISIONS(MAX_DIVISIONS)) u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_restart(in_ch.data),
        .ring_count(rings_reg), .segment_count(segs_reg),
        .cmd_valid(f_valid), .cmd_ready(f_ready), .cmd(f_cmd)
    );

    usm_queue u_queue (
        .clk(clk), .rst_n(rst_n),
        .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_cmd),
        .rd_valid(b_valid), .rd_ready(b_ready), .rd_data(b_cmd)
    );

    usm_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .clk(clk), .rst_n(rst_n),
        .cmd_valid(b_valid), .cmd_ready(b_ready), .cmd(b_cmd),
        .radius(radius_reg),
        .res_valid(out_ch.valid), .res_ready(out_ch.ready), .res(r)
    );

    assign out_ch.data = r;

endmodule

/* hdl/usm_front.sv */
// usm_front: walk sequencer. Accepts restart/advance words and emits one command per word, none once the walk is done.
// Depends on usm_pkg.
module usm_front #(
    parameter int MAX_DIVISIONS = 255
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        in_restart,
    input  logic [7:0]  ring_count,
    input  logic [7:0]  segment_count,
    output logic        cmd_valid,
    input  logic        cmd_ready,
    output usm_pkg::cmd_t cmd
);
    import usm_pkg::*;

    localparam logic [8:0] MAXD = 9'(MAX_DIVISIONS);

    phase_t      phase_reg, phase_next;
    logic [7:0]  ring_reg, ring_next;
    logic [7:0]  seg_reg, seg_next;
    logic        half_reg, half_next;
    logic [15:0] vtot_reg, vtot_next;

    logic [8:0]  nr, ns;
    phase_t      ph;
    logic [7:0]  r0, s0;
    logic        h0;
    logic [15:0] vt0;
    logic [15:0] cur, nxt;
    logic [7:0]  k, s_inc;
    logic [7:0]  r_inc;
    logic [15:0] rmul;

    always_comb
    begin
        nr = {1'b0, ring_count};
        if (nr < 9'd1) nr = 9'd1;
        if (nr > MAXD) nr = MAXD;
        ns = {1'b0, segment_count};
        if (ns < 9'd3) ns = 9'd3;
        if (ns > MAXD) ns = MAXD;
    end

    assign in_ready = cmd_ready;

    always_comb
    begin
        ph  = phase_reg;
        r0  = ring_reg;
        s0  = seg_reg;
        h0  = half_reg;
        vt0 = vtot_reg;
        if (in_restart)
        begin
            ph  = PH_NORTH;
            r0  = '0;
            s0  = '0;
            h0  = 1'b0;
            vt0 = 16'((ns + 9'd1) * nr + 18'd2);
        end
        s_inc = s0 + 8'd1;
        r_inc = r0 + 8'd1;
        k     = ({1'b0, s0} >= ns) ? 8'd0 : s0;
        rmul  = 16'({8'd0, r0} * ({7'd0, ns} + 16'd1));
        cur   = 16'({8'd0, s0}) + rmul + 16'd1;
        nxt   = cur + 16'(ns) + 16'd1;

        phase_next = ph;
        ring_next  = r0;
        seg_next   = s0;
        half_next  = h0;
        vtot_next  = vt0;

        cmd = '0;
        cmd.phase      = ph;
        cmd.ring_start = (s0 == 8'd0);
        cmd.polar_num  = 32'({r_inc, 23'd0});
        cmd.polar_den  = nr + 9'd1;
        cmd.azi_num    = {k, 32'd0};
        cmd.azi_den    = ns;

        unique case (ph)
            PH_NORTH:
            begin
                phase_next = PH_RING;
                ring_next  = '0;
                seg_next   = '0;
            end
            PH_RING:
            begin
                if ({1'b0, s0} >= ns)
                begin
                    seg_next  = '0;
                    ring_next = r_inc;
                    if ({1'b0, r_inc} >= nr) phase_next = PH_SOUTH;
                end
                else
                begin
                    seg_next = s_inc;
                end
            end
            PH_SOUTH:
            begin
                phase_next = PH_TOP;
                seg_next   = '0;
            end
            PH_TOP:
            begin
                cmd.index_a = 16'(s0) + 16'd2;
                cmd.index_b = 16'(s0) + 16'd1;
                cmd.index_c = 16'd0;
                seg_next    = s_inc;
                if ({1'b0, s_inc} >= ns)
                begin
                    seg_next   = '0;
                    ring_next  = '0;
                    half_next  = 1'b0;
                    phase_next = (nr >= 9'd2) ? PH_MID : PH_BOT;
                end
            end
            PH_MID:
            begin
                cmd.index_a = cur;
                if (!h0)
                begin
                    cmd.index_b = cur + 16'd1;
                    cmd.index_c = nxt + 16'd1;
                    half_next   = 1'b1;
                end
                else
                begin
                    cmd.index_b = nxt + 16'd1;
                    cmd.index_c = nxt;
                    half_next   = 1'b0;
                    seg_next    = s_inc;
                    if ({1'b0, s_inc} >= ns)
                    begin
                        seg_next  = '0;
                        ring_next = r_inc;
                        if ({1'b0, r_inc} + 9'd1 >= nr) phase_next = PH_BOT;
                    end
                end
            end
            PH_BOT:
            begin
                cmd.index_a = vt0 - 16'd1;
                cmd.index_b = vt0 - 16'(s_inc) - 16'd2;
                cmd.index_c = vt0 - 16'(s_inc) - 16'd1;
                cmd.last    = ({1'b0, s_inc} >= ns);
                seg_next    = cmd.last ? 8'd0 : s_inc;
                if (cmd.last) phase_next = PH_DONE;
            end
            default:
            begin
            end
        endcase
        cmd_valid = in_valid && (ph != PH_DONE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_DONE;
            ring_reg  <= '0;
            seg_reg   <= '0;
            half_reg  <= 1'b0;
            vtot_reg  <= '0;
        end
        else if (in_valid && in_ready)
        begin
            phase_reg <= phase_next;
            ring_reg  <= ring_next;
            seg_reg   <= seg_next;
            half_reg  <= half_next;
            vtot_reg  <= vtot_next;
        end
    end

endmodule

/* hdl/usm_queue.sv */
// usm_queue: two-entry command queue between sequencer and datapath.
// Depends on usm_pkg.
module usm_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_valid,
    output logic          wr_ready,
    input  usm_pkg::cmd_t wr_data,
    output logic          rd_valid,
    input  logic          rd_ready,
    output usm_pkg::cmd_t rd_data
);
    import usm_pkg::*;

    cmd_t       mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;

    assign wr_ready = (cnt_reg != 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_data  = mem_reg[rp_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_ff @(posedge clk)
    begin
        if (push) mem_reg[wp_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push) wp_reg <= ~wp_reg;
            if (pop) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

endmodule

/* hdl/usm_back.sv */
// usm_back: datapath. Angle division, iterative CORDIC, scaling, output register.
// Depends on usm_pkg.
module usm_back #(
    parameter int FRAC_BITS = 14
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_ready,
    input  usm_pkg::cmd_t cmd,
    input  logic [14:0]   radius,
    output logic          res_valid,
    input  logic          res_ready,
    output usm_pkg::result_t res
);
    import usm_pkg::*;

    typedef enum logic [3:0] {
        B_IDLE, B_PDIV, B_PCOR, B_PFIN, B_ADIV, B_ACOR, B_AFIN,
        B_MULU, B_MULP, B_EMIT
    } bstate_t;

    localparam logic signed [17:0] ONE = 18'sd1 <<< FRAC_BITS;
    localparam int SH = 30 - FRAC_BITS;

    bstate_t state_reg, state_next;
    cmd_t    cmd_reg;
    logic [39:0] num_reg;
    logic [31:0] quo_reg;
    logic [8:0]  rem_reg;
    logic [5:0]  cnt_reg;
    logic signed [33:0] x_reg, y_reg, z_reg;
    logic [1:0]  q_reg;
    logic signed [17:0] sin1_reg, cos1_reg, s2_reg, c2_reg;
    logic signed [17:0] ux_reg, uy_reg, uz_reg;
    logic signed [15:0] px_reg, py_reg, pz_reg;
    logic [1:0]  mstep_reg;
    result_t     out_reg;
    logic        out_valid_reg;

    logic [8:0]  den;
    logic [9:0]  trial;
    logic signed [33:0] dx, dy;
    logic signed [17:0] sr, cr, s_q, c_q;
    logic signed [17:0] ma;
    logic signed [17:0] mb;
    logic signed [35:0] prod;
    logic signed [17:0] prod_r;
    logic signed [33:0] pprod;
    logic signed [17:0] ppos;
    logic signed [17:0] nclip;
    logic        out_free;

    function automatic logic signed [17:0] clampu(input logic signed [33:0] v);
        logic signed [33:0] r;
        begin
            r = (v + (34'sd1 <<< (SH - 1))) >>> SH;
            if (r > 34'(ONE)) r = 34'(ONE);
            if (r < -34'(ONE)) r = -34'(ONE);
            return 18'(r);
        end
    endfunction

    function automatic logic signed [15:0] nclamp(input logic signed [17:0] v);
        logic signed [17:0] r;
        begin
            r = v;
            if (r > 18'sd32767) r = 18'sd32767;
            if (r < -18'sd32767) r = -18'sd32767;
            return 16'(r);
        end
    endfunction

    assign out_free  = !out_valid_reg || res_ready;
    assign cmd_ready = (state_reg == B_IDLE);
    assign res_valid = out_valid_reg;
    assign res       = out_reg;
    assign den       = (state_reg == B_PDIV) ? cmd_reg.polar_den : cmd_reg.azi_den;
    assign trial     = {rem_reg, num_reg[39]} - {1'b0, den};
    assign dx        = y_reg >>> cnt_reg[3:0];
    assign dy        = x_reg >>> cnt_reg[3:0];
    assign cr        = clampu(x_reg);
    assign sr        = clampu(y_reg);

    always_comb
    begin
        unique case (q_reg)
            2'd0:    begin c_q = cr;  s_q = sr;  end
            2'd1:    begin c_q = -sr; s_q = cr;  end
            2'd2:    begin c_q = -cr; s_q = -sr; end
            default: begin c_q = sr;  s_q = -cr; end
        endcase
    end

    // shared multipliers: one for sin1*cos2 / sin1*sin2, another for radius*u
    always_comb
    begin
        ma = sin1_reg;
        mb = (mstep_reg == 2'd0) ? c2_reg : s2_reg;
        prod = ma * mb;
        prod_r = 18'(((prod + (36'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS));
        unique case (mstep_reg)
            2'd0:    pprod = $signed({19'd0, radius}) * ux_reg;
            2'd1:    pprod = $signed({19'd0, radius}) * uy_reg;
            default: pprod = $signed({19'd0, radius}) * uz_reg;
        endcase
        ppos = 18'((pprod + (34'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS);
        nclip = '0;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                if (cmd_valid)
                begin
                    if (cmd.phase == PH_RING)
                        state_next = cmd.ring_start ? B_PDIV : B_ADIV;
                    else if (cmd.phase == PH_NORTH || cmd.phase == PH_SOUTH)
                        state_next = B_MULP;
                    else
                        state_next = B_EMIT;
                end
            end
            B_PDIV:  if (cnt_reg == 6'd39) state_next = B_PCOR;
            B_PCOR:  if (cnt_reg == 6'(CORDIC_STEPS - 1)) state_next = B_PFIN;
            B_PFIN:  state_next = B_ADIV;
            B_ADIV:  if (cnt_reg == 6'd39) state_next = B_ACOR;
            B_ACOR:  if (cnt_reg == 6'(CORDIC_STEPS - 1)) state_next = B_AFIN;
            B_AFIN:  state_next = B_MULU;
            B_MULU:  if (mstep_reg == 2'd1) state_next = B_MULP;
            B_MULP:  if (mstep_reg == 2'd2) state_next = B_EMIT;
            B_EMIT:  if (out_free) state_next = B_IDLE;
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            B_IDLE:
            begin
                cmd_reg   <= cmd;
                cnt_reg   <= '0;
                mstep_reg <= '0;
                num_reg   <= cmd.ring_start ? {cmd.polar_num, 8'd0} : cmd.azi_num;
                rem_reg   <= '0;
                ux_reg    <= '0;
                uz_reg    <= '0;
                uy_reg    <= (cmd.phase == PH_SOUTH) ? -ONE : ONE;
            end
            B_PDIV, B_ADIV:
            begin
                if (!trial[9])
                begin
                    rem_reg <= trial[8:0];
                    quo_reg <= {quo_reg[30:0], 1'b1};
                end
                else
                begin
                    rem_reg <= {rem_reg[7:0], num_reg[39]};
                    quo_reg <= {quo_reg[30:0], 1'b0};
                end
                num_reg <= {num_reg[38:0], 1'b0};
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd39)
                begin
                    cnt_reg <= '0;
                    x_reg   <= CORDIC_GAIN;
                    y_reg   <= '0;
                    q_reg   <= quo_reg[30:29];
                    z_reg   <= $signed({4'd0, quo_reg[28:0], !trial[9]});
                end
            end
            B_PCOR, B_ACOR:
            begin
                if (!z_reg[33])
                begin
                    x_reg <= x_reg - dx;
                    y_reg <= y_reg + dy;
                    z_reg <= z_reg - turn_atan(cnt_reg[3:0]);
                end
                else
                begin
                    x_reg <= x_reg + dx;
                    y_reg <= y_reg - dy;
                    z_reg <= z_reg + turn_atan(cnt_reg[3:0]);
                end
                cnt_reg <= (cnt_reg == 6'(CORDIC_STEPS - 1)) ? 6'd0 : cnt_reg + 6'd1;
            end
            B_PFIN:
            begin
                sin1_reg <= s_q;
                cos1_reg <= c_q;
                num_reg  <= cmd_reg.azi_num;
                rem_reg  <= '0;
            end
            B_AFIN:
            begin
                s2_reg    <= s_q;
                c2_reg    <= c_q;
                uy_reg    <= cos1_reg;
                mstep_reg <= '0;
            end
            B_MULU:
            begin
                if (mstep_reg == 2'd0) ux_reg <= prod_r;
                else uz_reg <= prod_r;
                mstep_reg <= (mstep_reg == 2'd1) ? 2'd0 : 2'd1;
            end
            B_MULP:
            begin
                unique case (mstep_reg)
                    2'd0:    px_reg <= 16'(ppos);
                    2'd1:    py_reg <= 16'(ppos);
                    default: pz_reg <= 16'(ppos);
                endcase
                mstep_reg <= mstep_reg + 2'd1;
            end
            default:
            begin
            end
        endcase
        if (state_reg == B_EMIT && out_free)
        begin
            out_reg.item_kind <= (cmd_reg.phase == PH_TOP || cmd_reg.phase == PH_MID
                                  || cmd_reg.phase == PH_BOT);
            out_reg.index_a <= cmd_reg.index_a;
            out_reg.index_b <= cmd_reg.index_b;
            out_reg.index_c <= cmd_reg.index_c;
            out_reg.last    <= cmd_reg.last;
            out_reg.pos_x   <= px_reg;
            out_reg.pos_y   <= py_reg;
            out_reg.pos_z   <= pz_reg;
            out_reg.norm_x  <= nclamp(ux_reg);
            out_reg.norm_y  <= nclamp(uy_reg + nclip);
            out_reg.norm_z  <= nclamp(uz_reg);
            if (cmd_reg.phase == PH_TOP || cmd_reg.phase == PH_MID
                || cmd_reg.phase == PH_BOT)
            begin
                out_reg.pos_x  <= '0;
                out_reg.pos_y  <= '0;
                out_reg.pos_z  <= '0;
                out_reg.norm_x <= '0;
                out_reg.norm_y <= '0;
                out_reg.norm_z <= '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == B_EMIT && out_free) out_valid_reg <= 1'b1;
            else if (res_ready) out_valid_reg <= 1'b0;
        end
    end

endmodule

/* tb/tb_uv_sphere_mesh_generator.sv */
// tb_uv_sphere_mesh_generator: self-checking bench for the UV sphere mesh generator.
// Drives restart/advance words, predicts vertex and triangle words, checks each one.
// Depends on usm_pkg, usm_if and the uv_sphere_mesh_generator RTL.
module tb_uv_sphere_mesh_generator;
    import usm_pkg::*;

    localparam int FRAC      = 14;
    localparam int MAX_DIV   = 255;
    localparam int WDOG_MAX  = 5000;
    localparam int NUM_WORDS = 1150;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [14:0] cfg_data;

    usm_if #(.T(logic))    in_ch ();
    usm_if #(.T(result_t)) out_ch ();

    uv_sphere_mesh_generator DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch.sink),
        .out_ch    (out_ch.source),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    logic    word_q[$];
    result_t mesh_q[$];
    int      fails;
    int      pushed;
    bit      quiet;
    int      in_gap;
    int      out_gap;
    int      out_seen;
    int      hold_left;
    bit      hold_done;
    int      wdog;

    // predictor state
    int unsigned m_radius, m_rings, m_segs;
    phase_t      m_phase;
    int unsigned m_ring, m_seg, m_half, m_vtot;
    longint      m_rsin, m_rcos;

    function automatic longint asr(input longint v, input int s);
        return v >>> s;
    endfunction

    function automatic longint rnd(input longint v, input int s);
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic longint clamp_one(input longint v);
        longint one;
        one = longint'(1) <<< FRAC;
        return v > one ? one : (v < -one ? -one : v);
    endfunction

    function automatic void cordic_sin_cos(input logic [31:0] ph, output longint s,
                                           output longint c);
        longint x, y, z, dx, dy, sr, cr;
        begin
            x = 64'sh26DD3B6A;
            y = 0;
            z = longint'(ph[29:0]);
            for (int i = 0; i < CORDIC_STEPS; i++) begin
                dx = asr(y, i);
                dy = asr(x, i);
                if (z >= 0) begin
                    x -= dx; y += dy; z -= longint'(turn_atan(i[3:0]));
                end else begin
                    x += dx; y -= dy; z += longint'(turn_atan(i[3:0]));
                end
            end
            cr = clamp_one(rnd(x, 30 - FRAC));
            sr = clamp_one(rnd(y, 30 - FRAC));
            case (ph[31:30])
                2'd0:    begin c = cr;  s = sr;  end
                2'd1:    begin c = -sr; s = cr;  end
                2'd2:    begin c = -cr; s = -sr; end
                default: begin c = sr;  s = -cr; end
            endcase
        end
    endfunction

    function automatic int unsigned eff(input int unsigned v, input int unsigned lo);
        return v < lo ? lo : (v > MAX_DIV ? MAX_DIV : v);
    endfunction

    function automatic longint nclip(input longint v);
        return v > 32767 ? 32767 : (v < -32767 ? -32767 : v);
    endfunction

    function automatic result_t vertex_word(input longint ux, input longint uy,
                                            input longint uz);
        result_t w;
        longint  r;
        begin
            w = '0;
            r = longint'(m_radius);
            w.pos_x  = 16'(rnd(r * ux, FRAC));
            w.pos_y  = 16'(rnd(r * uy, FRAC));
            w.pos_z  = 16'(rnd(r * uz, FRAC));
            w.norm_x = 16'(nclip(ux));
            w.norm_y = 16'(nclip(uy));
            w.norm_z = 16'(nclip(uz));
            return w;
        end
    endfunction

    function automatic result_t tri_word(input int unsigned a, input int unsigned b,
                                         input int unsigned c, input bit fin);
        result_t w;
        begin
            w = '0;
            w.item_kind = 1'b1;
            w.index_a = a[15:0];
            w.index_b = b[15:0];
            w.index_c = c[15:0];
            w.last = fin;
            return w;
        end
    endfunction

    // one walk step; returns 1 when a word comes out
    function automatic bit mesh_step(input logic restart, output result_t w);
        int unsigned     nr, ns, k, cur, nxt, v;
        longint          one, s2, c2;
        longint unsigned ph;
        bit              fin;
        begin
            nr = eff(m_rings, 1);
            ns = eff(m_segs, 3);
            one = longint'(1) <<< FRAC;
            w = '0;
            if (restart) begin
                m_phase = PH_NORTH;
                m_ring = 0; m_seg = 0; m_half = 0;
                m_vtot = ((ns + 1) * nr + 2) & 32'hFFFF;
            end
            case (m_phase)
                PH_NORTH: begin
                    w = vertex_word(0, one, 0);
                    m_phase = PH_RING; m_ring = 0; m_seg = 0;
                    return 1;
                end
                PH_RING: begin
                    k = m_seg >= ns ? 0 : m_seg;
                    if (m_seg == 0) begin
                        ph = ((longint'(m_ring) + 1) << 31) / (longint'(nr) + 1);
                        cordic_sin_cos(ph[31:0], m_rsin, m_rcos);
                    end
                    ph = (longint'(k) << 32) / longint'(ns);
                    cordic_sin_cos(ph[31:0], s2, c2);
                    w = vertex_word(rnd(m_rsin * c2, FRAC), m_rcos, rnd(m_rsin * s2, FRAC));
                    if (m_seg >= ns) begin
                        m_seg = 0;
                        m_ring = (m_ring + 1) & 8'hFF;
                        if (m_ring >= nr) m_phase = PH_SOUTH;
                    end else begin
                        m_seg++;
                    end
                    return 1;
                end
                PH_SOUTH: begin
                    w = vertex_word(0, -one, 0);
                    m_phase = PH_TOP; m_seg = 0;
                    return 1;
                end
                PH_TOP: begin
                    w = tri_word(m_seg + 2, m_seg + 1, 0, 0);
                    m_seg++;
                    if (m_seg >= ns) begin
                        m_seg = 0; m_ring = 0; m_half = 0;
                        m_phase = nr >= 2 ? PH_MID : PH_BOT;
                    end
                    return 1;
                end
                PH_MID: begin
                    cur = m_seg + m_ring * (ns + 1) + 1;
                    nxt = cur + ns + 1;
                    if (m_half == 0) begin
                        w = tri_word(cur, cur + 1, nxt + 1, 0);
                        m_half = 1;
                    end else begin
                        w = tri_word(cur, nxt + 1, nxt, 0);
                        m_half = 0;
                        m_seg++;
                        if (m_seg >= ns) begin
                            m_seg = 0;
                            m_ring = (m_ring + 1) & 8'hFF;
                            if (m_ring + 1 >= nr) m_phase = PH_BOT;
                        end
                    end
                    return 1;
                end
                PH_BOT: begin
                    v = m_vtot;
                    m_seg++;
                    fin = m_seg >= ns;
                    w = tri_word(v - 1, v - m_seg - 2, v - m_seg - 1, fin);
                    if (fin) begin
                        m_phase = PH_DONE; m_seg = 0;
                    end
                    return 1;
                end
                default: return 0;
            endcase
        end
    endfunction

    function automatic int unsigned walk_len(input int unsigned rc, input int unsigned sc);
        int unsigned nr, ns;
        begin
            nr = eff(rc, 1);
            ns = eff(sc, 3);
            return (ns + 1) * nr + 2 + 2 * ns * nr;
        end
    endfunction

    initial begin
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_RADIUS;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.data = 1'b0;
        out_ch.ready = 1'b0;
        repeat (9) begin
            #5 clk = 1'b1;
            #5 clk = 1'b0;
        end
        rst_n = 1'b1;
        forever #5 clk = ~clk;
    end

    // word driver
    always @(posedge clk) begin : drive_words
        bit v;
        if (rst_n) begin
            result_t w;
            if (in_ch.valid && in_ch.ready) begin
                if (mesh_step(in_ch.data, w)) mesh_q.push_back(w);
                void'(word_q.pop_front());
            end
            if (in_ch.valid && !in_ch.ready) begin
                v = 1'b1;
            end else if (in_gap > 0) begin
                in_gap--;
                v = 1'b0;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                in_gap = $urandom_range(1, 7) - 1;
                v = 1'b0;
            end else begin
                v = word_q.size() > 0;
            end
            in_ch.valid <= v;
            if (v && !(in_ch.valid && !in_ch.ready)) in_ch.data <= word_q[0];
        end
    end

    // result monitor
    always @(posedge clk) begin : check_words
        bit r;
        result_t e, a;
        if (rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                a = out_ch.data;
                out_seen++;
                if (mesh_q.size() == 0) begin
                    $error("unexpected word kind=%0d", a.item_kind);
                    fails++;
                end else begin
                    e = mesh_q.pop_front();
                    if (a.item_kind !== e.item_kind) begin
                        $error("item_kind exp %0d got %0d", e.item_kind, a.item_kind); fails++;
                    end
                    if (a.pos_x !== e.pos_x) begin
                        $error("pos_x exp %0d got %0d", e.pos_x, a.pos_x); fails++;
                    end
                    if (a.pos_y !== e.pos_y) begin
                        $error("pos_y exp %0d got %0d", e.pos_y, a.pos_y); fails++;
                    end
                    if (a.pos_z !== e.pos_z) begin
                        $error("pos_z exp %0d got %0d", e.pos_z, a.pos_z); fails++;
                    end
                    if (a.norm_x !== e.norm_x) begin
                        $error("norm_x exp %0d got %0d", e.norm_x, a.norm_x); fails++;
                    end
                    if (a.norm_y !== e.norm_y) begin
                        $error("norm_y exp %0d got %0d", e.norm_y, a.norm_y); fails++;
                    end
                    if (a.norm_z !== e.norm_z) begin
                        $error("norm_z exp %0d got %0d", e.norm_z, a.norm_z); fails++;
                    end
                    if (a.index_a !== e.index_a) begin
                        $error("index_a exp %0d got %0d", e.index_a, a.index_a); fails++;
                    end
                    if (a.index_b !== e.index_b) begin
                        $error("index_b exp %0d got %0d", e.index_b, a.index_b); fails++;
                    end
                    if (a.index_c !== e.index_c) begin
                        $error("index_c exp %0d got %0d", e.index_c, a.index_c); fails++;
                    end
                    if (a.last !== e.last) begin
                        $error("last exp %0d got %0d", e.last, a.last); fails++;
                    end
                end
            end
            if (!hold_done && out_seen >= 150) begin
                hold_done = 1'b1;
                hold_left = 400;
            end
            if (hold_left > 0) begin
                hold_left--;
                r = 1'b0;
            end else if (out_gap > 0) begin
                out_gap--;
                r = 1'b0;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                out_gap = $urandom_range(1, 7) - 1;
                r = 1'b0;
            end else begin
                r = 1'b1;
            end
            out_ch.ready <= r;
        end
    end

    always @(posedge clk) begin : watchdog
        if (rst_n) begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) wdog = 0;
            else wdog++;
            if (wdog >= WDOG_MAX) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    task automatic settle();
        while (word_q.size() > 0 || mesh_q.size() > 0) @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    task automatic set_regs(input int unsigned rad, input int unsigned rc, input int unsigned sc);
        settle();
        @(posedge clk);
        cfg_we <= 1'b1; cfg_index <= REG_RADIUS; cfg_data <= rad[14:0];
        @(posedge clk);
        cfg_index <= REG_RINGS; cfg_data <= {7'd0, rc[7:0]};
        @(posedge clk);
        cfg_index <= REG_SEGS; cfg_data <= {7'd0, sc[7:0]};
        @(posedge clk);
        cfg_we <= 1'b0;
        m_radius = rad; m_rings = rc; m_segs = sc;
    endtask

    task automatic push(input logic restart, input int unsigned n);
        repeat (n) begin
            word_q.push_back(restart);
            pushed++;
        end
    endtask

    initial begin
        int unsigned rad, rc, sc, len, cut;
        fails = 0; pushed = 0; quiet = 0;
        in_gap = 0; out_gap = 0; out_seen = 0; hold_left = 0; hold_done = 0; wdog = 0;
        m_radius = 256; m_rings = 8; m_segs = 16;
        m_phase = PH_DONE; m_ring = 0; m_seg = 0; m_half = 0; m_vtot = 0;
        m_rsin = 0; m_rcos = 0;
        @(posedge rst_n);
        // advance before any restart gives nothing
        push(0, 1);
        // zero radius, smallest mesh
        set_regs(0, 1, 3);
        push(1, 1); push(0, walk_len(1, 3) - 1); push(0, 1);
        // out-of-range counts clamp, full radius
        set_regs(32767, 0, 0);
        push(1, 1); push(0, walk_len(0, 0) - 1);
        // largest counts, cut short by restart
        set_regs(32767, 255, 255);
        push(1, 1); push(0, 3); push(1, 1); push(0, 2);
        while (pushed < NUM_WORDS) begin
            case ($urandom_range(0, 7))
                0:       rad = 0;
                1:       rad = 32767;
                default: rad = $urandom_range(0, 32767);
            endcase
            case ($urandom_range(0, 9))
                0:       begin rc = $urandom_range(0, 255); sc = 255; end
                1:       begin rc = 255; sc = $urandom_range(0, 2); end
                2:       begin rc = $urandom_range(0, 1); sc = $urandom_range(0, 2); end
                default: begin rc = $urandom_range(1, 4); sc = $urandom_range(3, 10); end
            endcase
            if (pushed > NUM_WORDS - 120) quiet = 1;
            set_regs(rad, rc, sc);
            len = walk_len(rc, sc);
            if (len > 60) len = $urandom_range(2, 40);
            else if ($urandom_range(0, 3) == 0) begin
                cut = $urandom_range(1, len);
                push(1, 1); push(0, cut - 1);
            end
            push(1, 1); push(0, len - 1);
            push(0, $urandom_range(0, 3));
        end
        settle();
        if (fails == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule

/* sim.f */
hdl/usm_pkg.sv
hdl/usm_if.sv
hdl/usm_front.sv
hdl/usm_queue.sv
hdl/usm_back.sv
hdl/uv_sphere_mesh_generator.sv
tb/tb_uv_sphere_mesh_generator.sv
